@@ hdl/hkrs_pkg.sv @@
// Shared types and constants for the held-key repeat scheduler.
// No dependencies.
package hkrs_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int CATCHUP_DEF = 4;
  localparam logic [9:0] MAX_RATE_RESET = 10'd100;
  localparam logic [9:0] MS_PER_S = 10'd1000;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [1:0] K_DISPATCH = 2'd0;
  localparam logic [1:0] K_ON       = 2'd1;
  localparam logic [1:0] K_OFF      = 2'd2;
  localparam logic [1:0] K_STATUS   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_RATE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_KEY   = 2'd3;

endpackage

@@ hdl/held_key_repeat_scheduler_unit.sv @@
// Held-key repeat scheduler: slot table, sequencer and one shared subtract/compare unit.
// Depends on hkrs_pkg.
//
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | op key_row key_col action rate_hz now_ms
// out     | out | out_valid / out_ready | kind out_action status last
// cfg     | in  | cfg_we                | cfg_data (max_rate_hz)
//
// Start: the ceil(1000/hz) restoring divider (one quotient bit a cycle through the shared
// subtractor), a search of the slots (key, then free slot), the slot write and the result
// beats, each loaded and then held until out_ready takes it.
// Release: a search of the slots plus beats. Tick: a scan of the slots, and for each firing
// a compare, a load and a wait. in_ready returns the cycle after the status beat.
// rst clears the table and the sequencer. A stalled output holds the sequencer in place.
module held_key_repeat_scheduler_unit
  import hkrs_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int CATCHUP_LIMIT = CATCHUP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  key_row,
  input  logic [7:0]  key_col,
  input  logic [15:0] action,
  input  logic [15:0] rate_hz,
  input  logic [15:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] out_action,
  output logic [1:0]  status,
  output logic        last,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(CATCHUP_LIMIT + 1);
  localparam logic [CW-1:0] CLIM = CW'(CATCHUP_LIMIT);
  localparam logic [SW-1:0] SMAX = SW'(SLOTS - 1);
  localparam logic [9:0] DIVIDEND = MS_PER_S - 10'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DISP, S_FIND, S_FREE, S_OFF, S_ON, S_WRITE,
    S_REL, S_TICK, S_TFIRE, S_STAT, S_WAIT
  } state_t;

  state_t state, ret;
  logic [9:0] max_rate;

  logic [SLOTS-1:0] sa;
  logic [7:0]  sr   [SLOTS];
  logic [7:0]  sc   [SLOTS];
  logic [15:0] sact [SLOTS];
  logic [9:0]  siv  [SLOTS];
  logic [15:0] slf  [SLOTS];

  logic [7:0]  r_row, r_col;
  logic [15:0] r_act, r_hz, r_now;
  logic [1:0]  r_st;
  logic [SW-1:0] idx, hit;
  logic [CW-1:0] cnt;
  // divider: quotient shifts into q, remainder in rem
  logic [9:0]  q;
  logic [16:0] rem;
  logic [3:0]  bitn;

  // shared subtractor
  logic [16:0] sub_a, sub_b, sub_d;
  always_comb begin
    sub_a = 17'(slf[idx]);
    sub_b = '0;
    if (state == S_DIV) begin
      sub_a = {rem[15:0], DIVIDEND[bitn]};
      sub_b = {1'b0, r_hz};
    end else begin
      sub_a = {1'b0, r_now};
      sub_b = {1'b0, slf[idx]};
    end
    sub_d = sub_a - sub_b;
  end

  logic [15:0] elapsed;
  assign elapsed = sub_d[15:0];
  logic div_ge;
  assign div_ge = !sub_d[16];
  logic last_slot;
  assign last_slot = (idx == SMAX);
  logic key_match;
  assign key_match = sa[idx] && sr[idx] == r_row && sc[idx] == r_col;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      out_valid <= 1'b0;
      max_rate <= MAX_RATE_RESET;
      sa <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        sr[i] <= '0; sc[i] <= '0; sact[i] <= '0; siv[i] <= '0; slf[i] <= '0;
      end
    end else begin
      if (cfg_we) max_rate <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            r_row <= key_row; r_col <= key_col;
            r_act <= action; r_hz <= rate_hz; r_now <= now_ms;
            r_st <= ST_OK; idx <= '0; cnt <= '0;
            q <= '0; rem <= '0; bitn <= 4'd9;
            case (op)
              OP_START: begin
                if (rate_hz == 16'd0 || rate_hz > 16'(max_rate)) begin
                  r_st <= ST_BAD_RATE;
                  state <= S_STAT;
                end else state <= S_DIV;
              end
              OP_RELEASE: state <= S_REL;
              OP_TICK:    state <= S_TICK;
              default:    state <= S_STAT;
            endcase
          end
        end
        S_DIV: begin
          // ceil(1000/hz) = floor(999/hz)+1: restoring divide over the 10 bits of 999
          if (div_ge) rem <= {1'b0, sub_d[15:0]};
          else rem <= {rem[15:0], DIVIDEND[bitn]};
          q <= {q[8:0], div_ge};
          if (bitn == 4'd0) state <= S_DISP;
          else bitn <= bitn - 4'd1;
        end
        S_DISP: begin
          q <= q + 10'd1;
          kind <= K_DISPATCH; out_action <= r_act; status <= ST_OK; last <= 1'b0;
          out_valid <= 1'b1;
          state <= S_WAIT; ret <= S_FIND;
        end
        S_FIND: begin
          if (key_match) begin
            hit <= idx;
            if (sact[idx] == r_act) state <= S_WRITE;
            else state <= S_OFF;
          end else if (last_slot) begin
            idx <= '0; state <= S_FREE;
          end else idx <= idx + 1'b1;
        end
        S_FREE: begin
          if (!sa[idx]) begin
            hit <= idx; state <= S_ON;
          end else if (last_slot) begin
            r_st <= ST_FULL; state <= S_STAT;
          end else idx <= idx + 1'b1;
        end
        S_OFF: begin
          kind <= K_OFF; out_action <= sact[hit]; status <= ST_OK; last <= 1'b0;
          out_valid <= 1'b1;
          state <= S_WAIT; ret <= S_ON;
        end
        S_ON: begin
          kind <= K_ON; out_action <= r_act; status <= ST_OK; last <= 1'b0;
          out_valid <= 1'b1;
          state <= S_WAIT; ret <= S_WRITE;
        end
        S_WRITE: begin
          sa[hit] <= 1'b1; sr[hit] <= r_row; sc[hit] <= r_col;
          sact[hit] <= r_act; siv[hit] <= q; slf[hit] <= r_now;
          state <= S_STAT;
        end
        S_REL: begin
          if (key_match) begin
            sa[idx] <= 1'b0; sr[idx] <= '0; sc[idx] <= '0;
            sact[idx] <= '0; siv[idx] <= '0; slf[idx] <= '0;
            kind <= K_OFF; out_action <= sact[idx]; status <= ST_OK; last <= 1'b0;
            out_valid <= 1'b1;
            state <= S_WAIT; ret <= S_STAT;
          end else if (last_slot) begin
            r_st <= ST_NO_KEY; state <= S_STAT;
          end else idx <= idx + 1'b1;
        end
        S_TICK: begin
          if (sa[idx] && cnt != CLIM && elapsed >= 16'(siv[idx])) begin
            slf[idx] <= slf[idx] + 16'(siv[idx]);
            cnt <= cnt + 1'b1;
            state <= S_TFIRE;
          end else if (last_slot) state <= S_STAT;
          else begin
            idx <= idx + 1'b1; cnt <= '0;
          end
        end
        S_TFIRE: begin
          kind <= K_DISPATCH; out_action <= sact[idx]; status <= ST_OK; last <= 1'b0;
          out_valid <= 1'b1;
          state <= S_WAIT; ret <= S_TICK;
        end
        S_STAT: begin
          kind <= K_STATUS; out_action <= '0; status <= r_st; last <= 1'b1;
          out_valid <= 1'b1;
          state <= S_WAIT; ret <= S_IDLE;
        end
        S_WAIT: begin
          // hold until the beat is taken
          if (out_valid && out_ready) state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_wait_has_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && !$past(state == S_WAIT)) |-> out_valid) else $error("no beat");
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == K_STATUS))) else $error("last mismatch");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (state == S_IDLE)) else $error("not idle");
`endif

endmodule

@@ sim/tb_held_key_repeat_scheduler_unit.sv @@
// Self-checking testbench for the held-key repeat scheduler: directed and random
// start/release/tick traffic against a behavioural slot-table predictor.
// Depends on hkrs_pkg and held_key_repeat_scheduler_unit.
`timescale 1ns / 100ps

module tb_held_key_repeat_scheduler_unit;
  import hkrs_pkg::*;

  localparam int NSLOT = 8;
  localparam int CATCH = 4;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] act;
    logic [1:0]  st;
    logic        last;
  } beat_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [1:0] op = '0;
  logic [7:0] key_row = '0, key_col = '0;
  logic [15:0] action = '0, rate_hz = '0, now_ms = '0;
  logic out_valid, out_ready = 0;
  logic [1:0] kind, status;
  logic [15:0] out_action;
  logic last;
  logic cfg_we = 0;
  logic [9:0] cfg_data = '0;

  held_key_repeat_scheduler_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .key_row(key_row), .key_col(key_col), .action(action), .rate_hz(rate_hz),
    .now_ms(now_ms), .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .out_action(out_action), .status(status), .last(last), .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [9:0]  max_rate;
  logic        b_act [NSLOT];
  logic [7:0]  b_row [NSLOT], b_col [NSLOT];
  logic [15:0] b_code [NSLOT], b_last [NSLOT];
  logic [9:0]  b_ivl [NSLOT];
  beat_t       pending_beats[$];
  int errors = 0, n_items = 0, n_beats = 0, n_cycles = 0;
  bit quiet = 0;
  logic [15:0] clock_ms = 0;

  task automatic report(string what, beat_t got, beat_t want);
    errors++;
    $display("MISMATCH %s: got k%0d a%h s%0d l%0d, want k%0d a%h s%0d l%0d", what,
             got.kind, got.act, got.st, got.last, want.kind, want.act, want.st, want.last);
  endtask

  function automatic void push_beat(logic [1:0] k, logic [15:0] a, logic [1:0] s);
    beat_t b;
    b.kind = k; b.act = a; b.st = s; b.last = (k == K_STATUS);
    pending_beats.push_back(b);
  endfunction

  function automatic int find_binding(logic [7:0] r, logic [7:0] c);
    for (int i = 0; i < NSLOT; i++)
      if (b_act[i] && b_row[i] == r && b_col[i] == c) return i;
    return -1;
  endfunction

  function automatic void predict_repeats(logic [1:0] o, logic [7:0] r, logic [7:0] c,
                                          logic [15:0] a, logic [15:0] hz, logic [15:0] t);
    logic [1:0] st;
    int s;
    int unsigned ivl;
    bit refresh;
    logic [15:0] el;
    st = ST_OK;
    if (o == OP_START) begin
      if (hz == 0 || hz > max_rate) st = ST_BAD_RATE;
      else begin
        ivl = (1000 + hz - 1) / hz;
        if (ivl == 0) ivl = 1;
        refresh = 1;
        push_beat(K_DISPATCH, a, ST_OK);
        s = find_binding(r, c);
        if (s < 0) begin
          for (int i = NSLOT - 1; i >= 0; i--) if (!b_act[i]) s = i;
        end else if (b_code[s] == a) refresh = 0;
        else push_beat(K_OFF, b_code[s], ST_OK);
        if (s < 0) st = ST_FULL;
        else begin
          if (refresh) push_beat(K_ON, a, ST_OK);
          b_act[s] = 1; b_row[s] = r; b_col[s] = c; b_code[s] = a;
          b_ivl[s] = ivl[9:0]; b_last[s] = t;
        end
      end
    end else if (o == OP_RELEASE) begin
      s = find_binding(r, c);
      if (s < 0) st = ST_NO_KEY;
      else begin
        push_beat(K_OFF, b_code[s], ST_OK);
        b_act[s] = 0; b_row[s] = 0; b_col[s] = 0; b_code[s] = 0; b_ivl[s] = 0; b_last[s] = 0;
      end
    end else if (o == OP_TICK) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!b_act[i]) continue;
        for (int k = 0; k < CATCH; k++) begin
          el = t - b_last[i];
          if (el < {6'd0, b_ivl[i]}) break;
          b_last[i] = b_last[i] + {6'd0, b_ivl[i]};
          push_beat(K_DISPATCH, b_code[i], ST_OK);
        end
      end
    end
    push_beat(K_STATUS, 16'd0, st);
  endfunction

  // send one beat, with occasional idle cycles ahead of it
  task automatic send_item(logic [1:0] o, logic [7:0] r, logic [7:0] c, logic [15:0] a,
                           logic [15:0] hz, logic [15:0] t);
    while (!quiet && $urandom_range(99) < 6) @(posedge clk);
    predict_repeats(o, r, c, a, hz, t);
    in_valid <= 1; op <= o; key_row <= r; key_col <= c; action <= a;
    rate_hz <= hz; now_ms <= t;
    do @(posedge clk); while (!in_ready);
    in_valid <= 0;
    // the block is busy after it accepts a beat, so step past this edge
    @(posedge clk);
    n_items++;
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst) out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
    if (!rst && out_valid && out_ready) begin
      got.kind = kind; got.act = out_action; got.st = status; got.last = last;
      n_beats++;
      if (pending_beats.size() == 0) begin
        want = '0;
        report("unexpected beat", got, want);
      end else begin
        want = pending_beats.pop_front();
        if (got.kind != want.kind) report("kind", got, want);
        else if (got.act != want.act) report("action", got, want);
        else if (got.st != want.st) report("status", got, want);
        else if (got.last != want.last) report("last", got, want);
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d beats outstanding", pending_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_max_rate(logic [9:0] v);
    drain();
    cfg_we <= 1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    max_rate = v;
  endtask

  task automatic tick_ms(int unsigned dt);
    clock_ms = clock_ms + dt[15:0];
    send_item(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), clock_ms);
  endtask

  task automatic test_rates();
    set_max_rate(10'd1000);
    send_item(OP_START, 8'd0, 8'd0, 16'h0000, 16'd1000, clock_ms);
    send_item(OP_START, 8'hff, 8'hff, 16'hffff, 16'd1, clock_ms);
    send_item(OP_START, 8'd1, 8'd2, 16'h1234, 16'd0, clock_ms);
    send_item(OP_START, 8'd1, 8'd2, 16'h1234, 16'd1001, clock_ms);
    send_item(OP_START, 8'd1, 8'd2, 16'h1234, 16'hffff, clock_ms);
    send_item(OP_START, 8'd3, 8'd3, 16'h5555, 16'd3, clock_ms);
    send_item(OP_START, 8'd3, 8'd3, 16'h5555, 16'd7, clock_ms); // same action: no notes
    send_item(OP_START, 8'd3, 8'd3, 16'haaaa, 16'd333, clock_ms); // replace: off then on
    set_max_rate(10'd0);
    send_item(OP_START, 8'd4, 8'd4, 16'h0001, 16'd1, clock_ms);
    set_max_rate(10'd1000);
  endtask

  task automatic test_ticks_and_release();
    tick_ms(0);
    tick_ms(1);
    tick_ms(5000);   // catch-up capped
    tick_ms(1);
    tick_ms(40000);  // long gap: catch-up capped again
    send_item(OP_RELEASE, 8'd3, 8'd3, 16'd0, 16'd0, clock_ms);
    send_item(OP_RELEASE, 8'd3, 8'd3, 16'd0, 16'd0, clock_ms); // now unbound
    send_item(2'd3, 8'd9, 8'd9, 16'h7777, 16'd5, clock_ms);    // unused op
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NSLOT + 1; i++)
      send_item(OP_START, 8'd20, i[7:0], 16'h0100 + i[15:0], 16'd500, clock_ms);
    tick_ms(2);
    for (int i = 0; i < NSLOT + 1; i++)
      send_item(OP_RELEASE, 8'd20, i[7:0], 16'd0, 16'd0, clock_ms);
    // drop the first bindings so the random part starts with a mostly empty table
    send_item(OP_RELEASE, 8'd0, 8'd0, 16'd0, 16'd0, clock_ms);
    send_item(OP_RELEASE, 8'hff, 8'hff, 16'd0, 16'd0, clock_ms);
  endtask

  task automatic test_random(int n, logic [9:0] rate);
    int unsigned p;
    set_max_rate(rate);
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 35)
        send_item(OP_START, 8'($urandom_range(3)), 8'($urandom_range(3)),
                  16'($urandom_range(5) * 16'h3001),
                  (p < 5) ? 16'($urandom) : 16'($urandom_range(1, rate + 2)), clock_ms);
      else if (p < 55)
        send_item(OP_RELEASE, 8'($urandom_range(3)),
                  (p < 38) ? 8'($urandom) : 8'($urandom_range(3)),
                  16'($urandom), 16'($urandom), clock_ms);
      else if (p < 97)
        tick_ms((p < 94) ? $urandom_range(40) : $urandom);
      else
        send_item(2'd3, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    end
  endtask

  initial begin
    max_rate = MAX_RATE_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      b_act[i] = 0; b_row[i] = 0; b_col[i] = 0; b_code[i] = 0; b_ivl[i] = 0; b_last[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(OP_START, 8'd7, 8'd7, 16'h00aa, 16'd100, clock_ms); // reset rate limit
    send_item(OP_START, 8'd7, 8'd8, 16'h00bb, 16'd101, clock_ms);
    send_item(OP_RELEASE, 8'd7, 8'd7, 16'd0, 16'd0, clock_ms);
    test_rates();
    test_ticks_and_release();
    test_table_full();
    test_random(25, 10'd1000);
    quiet = 1;
    test_random(20, 10'd250);
    quiet = 0;
    test_random(15, 10'd1);
    drain();
    $display("Sent %0d requests, checked %0d result beats over rate limits 0..1000.",
             n_items, n_beats);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/hkrs_pkg.sv
hdl/held_key_repeat_scheduler_unit.sv
sim/tb_held_key_repeat_scheduler_unit.sv
